@@ hw/rtl/stx_pkg.sv @@
// shared types, constants and codes for the stx/etx frame receiver
// used by every module of the receiver; depends on nothing
package stx_pkg;

    localparam int BUF_LEN = 32;
    localparam int ADDR_W  = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;
    localparam int LEN_W   = 6;

    localparam logic [7:0]       BUF_LEN_B = 8'(BUF_LEN);
    localparam logic [LEN_W-1:0] BUF_LEN_L = LEN_W'(BUF_LEN);
    localparam logic [7:0]       GAP_MAX   = 8'd255;

    localparam logic [7:0] TIMEOUT_RESET = 8'd10;
    localparam logic [7:0] START_RESET   = 8'd2;
    localparam logic [7:0] END_RESET     = 8'd3;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_START   = 2'd1;
    localparam logic [1:0] CFG_END     = 2'd2;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_END
    } t_parse_phase;

    typedef enum logic [0:0] {
        EM_IDLE,
        EM_DATA
    } t_emit_state;

    // one completed frame as handed from parser to emitter
    typedef struct packed {
        logic [7:0]       cmd;
        logic [LEN_W-1:0] len;
        logic             trunc;
    } t_frame_desc;

    // payload store write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    // parser configuration
    typedef struct packed {
        logic [7:0] timeout_ms;
        logic [7:0] start_code;
        logic [7:0] end_code;
    } t_cfg;

endpackage

@@ hw/rtl/stx_frame_parser.sv @@
// front part: accepts bytes and ticks, runs the frame parser, writes the payload store
// depends on stx_pkg
module stx_frame_parser
    import stx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_accept,
    input  logic        i_func,
    input  logic [7:0]  i_rx_byte,
    output t_mem_wr     o_mem_wr,
    output logic        o_push,
    output t_frame_desc o_desc
);

    t_parse_phase r_phase, n_phase;
    logic [7:0]   r_cmd, n_cmd;
    logic [7:0]   r_decl_len, n_decl_len;
    logic [7:0]   r_rcvd, n_rcvd;
    logic [7:0]   r_gap, n_gap;

    t_parse_phase w_eff_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cmd      <= 8'd0;
            r_decl_len <= 8'd0;
            r_rcvd     <= 8'd0;
            r_gap      <= 8'd0;
        end else begin
            r_phase    <= n_phase;
            r_cmd      <= n_cmd;
            r_decl_len <= n_decl_len;
            r_rcvd     <= n_rcvd;
            r_gap      <= n_gap;
        end
    end

    // descriptor always reflects the frame being closed
    always_comb begin
        o_desc.cmd = r_cmd;
        if (r_decl_len > BUF_LEN_B) begin
            o_desc.len   = BUF_LEN_L;
            o_desc.trunc = 1'b1;
        end else begin
            o_desc.len   = r_decl_len[LEN_W-1:0];
            o_desc.trunc = 1'b0;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_cmd      = r_cmd;
        n_decl_len = r_decl_len;
        n_rcvd     = r_rcvd;
        n_gap      = r_gap;
        o_push     = 1'b0;
        o_mem_wr.en   = 1'b0;
        o_mem_wr.addr = r_rcvd[ADDR_W-1:0];
        o_mem_wr.data = i_rx_byte;

        // gap timeout drops back to idle before the byte is parsed
        w_eff_phase = (r_gap > i_cfg.timeout_ms) ? PH_IDLE : r_phase;

        if (i_accept) begin
            if (i_func == FUNC_TICK) begin
                if (r_gap != GAP_MAX) begin
                    n_gap = r_gap + 8'd1;
                end
            end else begin
                n_gap = 8'd0;
                case (w_eff_phase)
                    PH_CMD: begin
                        n_cmd   = i_rx_byte;
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        n_decl_len = i_rx_byte;
                        n_phase    = (i_rx_byte != 8'd0) ? PH_DATA : PH_END;
                    end
                    PH_DATA: begin
                        o_mem_wr.en = (r_rcvd < BUF_LEN_B);
                        n_rcvd      = r_rcvd + 8'd1;
                        if (n_rcvd >= r_decl_len) begin
                            n_phase = PH_END;
                        end
                    end
                    PH_END: begin
                        if (i_rx_byte == i_cfg.end_code) begin
                            o_push  = 1'b1;
                            n_phase = PH_IDLE;
                        end else if (i_rx_byte == i_cfg.start_code) begin
                            o_push  = 1'b1;
                            n_phase = PH_CMD;
                            n_cmd   = 8'd0;
                            n_rcvd  = 8'd0;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (i_rx_byte == i_cfg.start_code) begin
                            n_phase = PH_CMD;
                            n_cmd   = 8'd0;
                            n_rcvd  = 8'd0;
                        end
                    end
                endcase
            end
        end
    end

endmodule

@@ hw/rtl/stx_desc_fifo.sv @@
// two-entry queue of completed frame descriptors between parser and emitter
// depends on stx_pkg
module stx_desc_fifo
    import stx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_frame_desc i_desc,
    input  logic        i_pop,
    output logic        o_not_empty,
    output t_frame_desc o_desc
);

    t_frame_desc r_slot [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    logic w_push;
    logic w_pop;

    assign o_not_empty = (r_count != 2'd0);
    assign o_desc      = r_slot[r_rd_ptr];
    assign w_push      = i_push && (r_count != 2'd2);
    assign w_pop       = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_desc;
        end
    end

endmodule

@@ hw/rtl/stx_result_emitter.sv @@
// back part: owns the payload store and replays a completed frame as result beats
// depends on stx_pkg
module stx_result_emitter
    import stx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mem_wr          i_mem_wr,
    input  logic             i_desc_valid,
    input  t_frame_desc      i_desc,
    output logic             o_pop,
    output logic             o_busy,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_item_kind,
    output logic [7:0]       o_command,
    output logic [7:0]       o_payload_byte,
    output logic [LEN_W-1:0] o_payload_len,
    output logic             o_truncated,
    output logic             o_last
);

    logic [7:0] r_mem [BUF_LEN];
    logic [7:0] r_rd_data;

    t_emit_state      r_state, n_state;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;
    logic             w_load_hdr;
    logic             w_load_pay;
    logic [ADDR_W-1:0] w_rd_addr;

    // output register side fields
    logic             r_kind;
    logic [7:0]       r_cmd;
    logic [7:0]       r_byte;
    logic [LEN_W-1:0] r_len;
    logic             r_trunc;
    logic             r_last;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_busy     = (r_state != EM_IDLE);

    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= EM_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        w_load_hdr  = 1'b0;
        w_load_pay  = 1'b0;
        o_pop       = 1'b0;
        case (r_state)
            EM_IDLE: begin
                if (i_desc_valid && w_out_free) begin
                    w_load_hdr  = 1'b1;
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    n_idx       = '0;
                    if (i_desc.len != '0) begin
                        n_state = EM_DATA;
                    end
                end
            end
            EM_DATA: begin
                if (w_out_free) begin
                    w_load_pay  = 1'b1;
                    n_out_valid = 1'b1;
                    n_idx       = r_idx + LEN_W'(1);
                    if (n_idx == r_len) begin
                        n_state = EM_IDLE;
                    end
                end
            end
            default: begin
                n_state = EM_IDLE;
            end
        endcase
        // read ahead so the data register holds the entry at the next index
        w_rd_addr = (n_idx < BUF_LEN_L) ? n_idx[ADDR_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_load_hdr) begin
            r_kind  <= KIND_HEADER;
            r_cmd   <= i_desc.cmd;
            r_byte  <= 8'd0;
            r_len   <= i_desc.len;
            r_trunc <= i_desc.trunc;
            r_last  <= (i_desc.len == '0);
        end else if (w_load_pay) begin
            r_kind  <= KIND_PAYLOAD;
            r_byte  <= r_rd_data;
            r_last  <= (n_idx == r_len);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_item_kind    = r_kind;
    assign o_command      = r_cmd;
    assign o_payload_byte = r_byte;
    assign o_payload_len  = r_len;
    assign o_truncated    = r_trunc;
    assign o_last         = r_last;

endmodule

@@ hw/rtl/stx_etx_frame_receiver_unit.sv @@
// stx/etx frame receiver, top level: config registers, parser, descriptor queue, emitter
// depends on stx_pkg, stx_frame_parser, stx_desc_fifo, stx_result_emitter
// a closing byte's descriptor is registered in the queue, then the emitter registers its header beat,
// then one payload beat a cycle while the output is not stalled; one input beat a cycle, but after a
//   closing byte input stalls until the replay of that frame is issued
// reset: synchronous active low; parser idle, gap count zero, queue empty, registers to defaults
module stx_etx_frame_receiver_unit
    import stx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input beats: bytes and millisecond ticks
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_func,
    input  logic [7:0]       i_rx_byte,
    // result beats
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_item_kind,
    output logic [7:0]       o_command,
    output logic [7:0]       o_payload_byte,
    output logic [LEN_W-1:0] o_payload_len,
    output logic             o_truncated,
    output logic             o_last,
    // configuration writes
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data
);

    t_cfg        r_cfg;
    logic        w_in_accept;
    t_mem_wr     w_mem_wr;
    logic        w_push;
    t_frame_desc w_push_desc;
    logic        w_pop;
    logic        w_fifo_not_empty;
    t_frame_desc w_pop_desc;
    logic        w_em_busy;

    // config writes are always taken; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms <= TIMEOUT_RESET;
            r_cfg.start_code <= START_RESET;
            r_cfg.end_code   <= END_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TIMEOUT: r_cfg.timeout_ms <= i_cfg_data;
                CFG_START:   r_cfg.start_code <= i_cfg_data;
                CFG_END:     r_cfg.end_code   <= i_cfg_data;
                default:     r_cfg            <= r_cfg;
            endcase
        end
    end

    // hold input while a completed frame is queued or being replayed, so the
    // payload store is never overwritten under the emitter; the last result
    // beat may still be waiting in the output register
    assign o_in_stall  = w_fifo_not_empty || w_em_busy;
    assign w_in_accept = i_in_valid && !o_in_stall;

    stx_frame_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (w_in_accept),
        .i_func    (i_func),
        .i_rx_byte (i_rx_byte),
        .o_mem_wr  (w_mem_wr),
        .o_push    (w_push),
        .o_desc    (w_push_desc)
    );

    stx_desc_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_desc      (w_push_desc),
        .i_pop       (w_pop),
        .o_not_empty (w_fifo_not_empty),
        .o_desc      (w_pop_desc)
    );

    stx_result_emitter u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mem_wr       (w_mem_wr),
        .i_desc_valid   (w_fifo_not_empty),
        .i_desc         (w_pop_desc),
        .o_pop          (w_pop),
        .o_busy         (w_em_busy),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_item_kind    (o_item_kind),
        .o_command      (o_command),
        .o_payload_byte (o_payload_byte),
        .o_payload_len  (o_payload_len),
        .o_truncated    (o_truncated),
        .o_last         (o_last)
    );

    // no store write may happen while a frame waits or replays
    a_no_write_in_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fifo_not_empty || w_em_busy) |-> !w_mem_wr.en)
        else $error("payload store written during replay");

    // a header beat is last exactly when the frame has no stored payload
    a_header_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_item_kind == KIND_HEADER)) |-> (o_last == (o_payload_len == '0)))
        else $error("header last flag does not match length");

    // stored length never exceeds the buffer
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_payload_len <= BUF_LEN_L))
        else $error("payload length beyond buffer");

    // a taken non-last beat is followed at once by the next beat of the frame
    a_no_gap_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=> (o_out_valid && (o_item_kind == KIND_PAYLOAD)))
        else $error("gap inside a frame replay");

endmodule

@@ sim/tb_stx_etx_frame_receiver_unit.sv @@
// self-checking testbench for the stx/etx frame receiver top level
// depends on stx_pkg and stx_etx_frame_receiver_unit; directed table, then random framed traffic
`timescale 1ns / 1ps

module tb_stx_etx_frame_receiver_unit;
    import stx_pkg::*;

    localparam int IDLE_PCT       = 10;   // chance per cycle or per beat of an idle
    localparam int DRAIN_CYCLES   = 40;   // extra settle time once every owed beat has arrived
    localparam int HOLDOFF_CYCLES = 300;  // long receiver hold-off to back up the input
    localparam int WATCHDOG_LIMIT = 5000; // cycles with no beat accepted on any channel
    localparam int RANDOM_ITEMS   = 320;  // input beats in the run before the random part winds down

    // one result beat as the block should present it
    typedef struct packed {
        logic             kind;
        logic [7:0]       cmd;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic             trunc;
        logic             last;
    } t_result;

    // directed table: a byte, a tick, a register write, or a byte that closes a
    // zero length frame whose single header beat is typed in the table
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_TICK,
        ROW_CFG,
        ROW_CLOSE
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [7:0] data;
        logic [7:0] aux;    // register index for ROW_CFG, header command for ROW_CLOSE
    } t_row;

    // clock, reset and stimulus, all inputs known from time zero
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_func   = FUNC_BYTE;
    logic [7:0]       in_byte   = 8'h00;
    logic             out_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [1:0]       cfg_index = CFG_TIMEOUT;
    logic [7:0]       cfg_data  = 8'h00;

    logic             in_stall;
    logic             out_valid;
    logic             out_kind;
    logic [7:0]       out_cmd;
    logic [7:0]       out_data;
    logic [LEN_W-1:0] out_len;
    logic             out_trunc;
    logic             out_last;
    logic             cfg_ready;

    // shadow copy of the parser and its registers
    t_parse_phase     frame_phase;
    logic [7:0]       cur_cmd;
    logic [7:0]       decl_len;
    logic [7:0]       rx_count;
    logic [7:0]       gap_ticks;
    logic [7:0]       shadow_store [BUF_LEN];
    logic [7:0]       cfg_timeout;
    logic [7:0]       cfg_start;
    logic [7:0]       cfg_end;

    t_result          frame_beats[$];      // beats caused by the last accepted input
    t_result          pending_results[$];  // beats still owed by the block
    t_row             dir_q[$];

    // run bookkeeping
    bit               no_idle = 1'b0;
    bit               frame_open = 1'b0;   // last frame was closed by a start code
    int               holdoff_asked = 0;
    int               holdoff_served = 0;
    int               holdoff_left = 0;
    int               quiet_cycles = 0;
    int               mismatches = 0;
    int               beats_sent = 0;
    int               bytes_sent = 0;
    int               results_checked = 0;
    int               headers_seen = 0;
    int               cfg_writes = 0;
    int               settings = 0;
    t_result          got;
    t_result          want;

    stx_etx_frame_receiver_unit u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_func         (in_func),
        .i_rx_byte      (in_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_item_kind    (out_kind),
        .o_command      (out_cmd),
        .o_payload_byte (out_data),
        .o_payload_len  (out_len),
        .o_truncated    (out_trunc),
        .o_last         (out_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // 8 ns clock
    initial begin
        forever #4 clk = ~clk;
    end

    // header beat, then one beat per stored payload byte, last on the final one
    function automatic void replay_frame();
        logic [LEN_W-1:0] stored;
        logic             trunc;
        trunc  = (decl_len > BUF_LEN_B);
        stored = trunc ? BUF_LEN_L : decl_len[LEN_W-1:0];
        frame_beats.push_back('{KIND_HEADER, cur_cmd, 8'h00, stored, trunc, stored == 0});
        for (int k = 0; k < stored; k++) begin
            frame_beats.push_back('{KIND_PAYLOAD, cur_cmd, shadow_store[k], stored, trunc,
                                    (k + 1) == stored});
        end
    endfunction

    // advance the shadow parser by one accepted input beat
    function automatic void parse_beat(input logic func, input logic [7:0] b);
        frame_beats.delete();
        if (func == FUNC_TICK) begin
            // gap count saturates rather than wrapping
            if (gap_ticks != GAP_MAX)
                gap_ticks = gap_ticks + 8'd1;
        end else begin
            // a byte after too long a gap drops any partial frame first
            if (gap_ticks > cfg_timeout)
                frame_phase = PH_IDLE;
            gap_ticks = 8'h00;
            case (frame_phase)
                PH_CMD: begin
                    cur_cmd     = b;
                    frame_phase = PH_LEN;
                end
                PH_LEN: begin
                    decl_len = b;
                    if (b != 8'h00)
                        frame_phase = PH_DATA;
                    else
                        frame_phase = PH_END;
                end
                PH_DATA: begin
                    // bytes past the buffer are counted but not stored
                    if (rx_count < BUF_LEN_B)
                        shadow_store[rx_count] = b;
                    rx_count = rx_count + 8'd1;
                    if (rx_count >= decl_len)
                        frame_phase = PH_END;
                end
                PH_END: begin
                    // end code wins when both codes are equal; other bytes ignored
                    if (b == cfg_end) begin
                        replay_frame();
                        frame_phase = PH_IDLE;
                    end else if (b == cfg_start) begin
                        replay_frame();
                        frame_phase = PH_CMD;
                        cur_cmd     = 8'h00;
                        rx_count    = 8'h00;
                    end
                end
                default: begin
                    frame_phase = PH_IDLE;
                    if (b == cfg_start) begin
                        frame_phase = PH_CMD;
                        cur_cmd     = 8'h00;
                        rx_count    = 8'h00;
                    end
                end
            endcase
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic [7:0] data,
                                    input logic [7:0] aux);
        dir_q.push_back('{kind, data, aux});
    endfunction

    // offer one input beat, hold it until accepted, then predict
    task automatic offer(input logic func, input logic [7:0] b);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_func  <= func;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        parse_beat(func, b);
        beats_sent++;
        if (func == FUNC_BYTE)
            bytes_sent++;
    endtask

    task automatic feed(input logic func, input logic [7:0] b);
        offer(func, b);
        for (int k = 0; k < frame_beats.size(); k++)
            pending_results.push_back(frame_beats[k]);
    endtask

    // stop offering, let every owed beat arrive, then give the block time to settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_TIMEOUT: cfg_timeout = val;
            CFG_START:   cfg_start   = val;
            CFG_END:     cfg_end     = val;
            default: ;
        endcase
        cfg_writes++;
        // drop valid in a step of its own so back-to-back writes stay clean
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ticks before a byte: mostly none, some within the limit, a few past it unless the limit is GAP_MAX
    task automatic gap_fill(input int abandon_pct);
        int r;
        int n;
        n = 0;
        r = $urandom_range(99);
        if (r < abandon_pct)
            n = (cfg_timeout == GAP_MAX) ? 4 : cfg_timeout + 1;
        else if (r < abandon_pct + 12)
            n = $urandom_range(0, (cfg_timeout < 3) ? cfg_timeout : 3);
        repeat (n) feed(FUNC_TICK, 8'($urandom));
    endtask

    // one well-formed frame with random content, or a short burst of noise
    task automatic random_frame();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 10) begin
            // stray bytes outside any frame structure
            repeat ($urandom_range(1, 4)) begin
                gap_fill(5);
                feed(FUNC_BYTE, 8'($urandom));
            end
            frame_open = 1'b0;
        end else begin
            gap_fill(8);
            if (!frame_open)
                feed(FUNC_BYTE, cfg_start);
            gap_fill(1);
            feed(FUNC_BYTE, 8'($urandom));
            // short frames mostly, some around the buffer size, a few far past it
            r = $urandom_range(99);
            if (r < 65)
                len = $urandom_range(0, 6);
            else if (r < 90)
                len = $urandom_range(28, 36);
            else if (r < 97)
                len = $urandom_range(37, 64);
            else
                len = $urandom_range(65, 255);
            gap_fill(1);
            feed(FUNC_BYTE, 8'(len));
            for (int k = 0; k < len; k++) begin
                gap_fill(1);
                feed(FUNC_BYTE, 8'($urandom));
            end
            // bytes while waiting for the end code, then close by end or start code
            r = $urandom_range(99);
            if (r < 15) begin
                repeat ($urandom_range(1, 3)) begin
                    gap_fill(1);
                    feed(FUNC_BYTE, 8'($urandom));
                end
            end
            gap_fill(1);
            if (r >= 15 && r < 40) begin
                feed(FUNC_BYTE, cfg_start);
                frame_open = 1'b1;
            end else begin
                feed(FUNC_BYTE, cfg_end);
                frame_open = 1'b0;
            end
        end
    endtask

    // receiver: random stalls, a long hold-off on request, none in the quiet phase
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (holdoff_left != 0) begin
            out_stall    <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_served != holdoff_asked) begin
            holdoff_served <= holdoff_asked;
            holdoff_left   <= HOLDOFF_CYCLES;
            out_stall      <= 1'b1;
        end else begin
            out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // result checker: every accepted beat against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            got = '{out_kind, out_cmd, out_data, out_len, out_trunc, out_last};
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %p", $time, got);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("item_kind", want.kind, got.kind);
                check_field("command", want.cmd, got.cmd);
                check_field("payload_byte", want.data, got.data);
                check_field("payload_len", want.len, got.len);
                check_field("truncated", want.trunc, got.trunc);
                check_field("last", want.last, got.last);
                if (want.kind == KIND_HEADER)
                    headers_seen++;
            end
            results_checked++;
        end
    end

    // watchdog on cycles in which no channel moves a beat
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles, %0d results still owed",
                     $time, WATCHDOG_LIMIT, pending_results.size());
            $display("tb_stx_etx_frame_receiver_unit failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [7:0] to_val;
        logic [7:0] sc_val;
        logic [7:0] ec_val;
        int         p;

        // shadow state after reset
        frame_phase = PH_IDLE;
        cur_cmd     = 8'h00;
        decl_len    = 8'h00;
        rx_count    = 8'h00;
        gap_ticks   = 8'h00;
        cfg_timeout = TIMEOUT_RESET;
        cfg_start   = START_RESET;
        cfg_end     = END_RESET;
        for (int k = 0; k < BUF_LEN; k++)
            shadow_store[k] = 8'h00;

        // directed table, run at the reset register values first
        // zero length frame closed by the end code
        add_row(ROW_BYTE,  START_RESET, 8'h00);
        add_row(ROW_BYTE,  8'hA5,       8'h00);
        add_row(ROW_BYTE,  8'h00,       8'h00);
        add_row(ROW_CLOSE, END_RESET,   8'hA5);
        // two payload bytes at both extremes, a stray byte, closed by a start code
        add_row(ROW_BYTE,  START_RESET, 8'h00);
        add_row(ROW_BYTE,  8'h11,       8'h00);
        add_row(ROW_BYTE,  8'h02,       8'h00);
        add_row(ROW_BYTE,  8'h00,       8'h00);
        add_row(ROW_BYTE,  8'hFF,       8'h00);
        add_row(ROW_BYTE,  8'h55,       8'h00);
        add_row(ROW_BYTE,  START_RESET, 8'h00);
        // frame opened by that start code: zero length, closed by another start code
        add_row(ROW_BYTE,  8'h22,       8'h00);
        add_row(ROW_BYTE,  8'h00,       8'h00);
        add_row(ROW_CLOSE, START_RESET, 8'h22);
        // partial frame abandoned by a gap past a zero timeout
        add_row(ROW_BYTE,  8'hFF,       8'h00);
        add_row(ROW_BYTE,  8'h01,       8'h00);
        add_row(ROW_CFG,   8'h00,       8'(CFG_TIMEOUT));
        add_row(ROW_TICK,  8'hFF,       8'h00);
        add_row(ROW_BYTE,  8'h80,       8'h00);
        // equal start and end codes: the end code wins
        add_row(ROW_CFG,   8'hFF,       8'(CFG_START));
        add_row(ROW_CFG,   8'hFF,       8'(CFG_END));
        add_row(ROW_BYTE,  8'hFF,       8'h00);
        add_row(ROW_BYTE,  8'h00,       8'h00);
        add_row(ROW_BYTE,  8'h00,       8'h00);
        add_row(ROW_CLOSE, 8'hFF,       8'h00);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        settings = 1;
        foreach (dir_q[i]) begin
            case (dir_q[i].kind)
                ROW_CFG: begin
                    drain();
                    write_reg(dir_q[i].aux[1:0], dir_q[i].data);
                end
                ROW_TICK: feed(FUNC_TICK, dir_q[i].data);
                ROW_BYTE: feed(FUNC_BYTE, dir_q[i].data);
                default: begin
                    // typed header of a zero length frame
                    offer(FUNC_BYTE, dir_q[i].data);
                    pending_results.push_back('{KIND_HEADER, dir_q[i].aux, 8'h00, '0,
                                                1'b0, 1'b1});
                end
            endcase
        end

        // random part: one register setting per phase, extremes in the early phases
        for (p = 0; p < 6 || beats_sent < RANDOM_ITEMS; p++) begin
            drain();
            sc_val = 8'($urandom);
            ec_val = 8'($urandom);
            case (p)
                0: begin
                    to_val = TIMEOUT_RESET;
                    sc_val = START_RESET;
                    ec_val = END_RESET;
                end
                1: begin
                    to_val = 8'h00;
                    sc_val = 8'h00;
                    ec_val = 8'hFF;
                end
                2: begin
                    to_val = 8'hFF;
                    sc_val = 8'hFF;
                    ec_val = 8'h00;
                end
                3: begin
                    to_val = 8'($urandom_range(1, 20));
                    ec_val = sc_val;
                end
                // timeout just below the gap ceiling
                5: to_val = 8'hFE;
                default: begin
                    if ($urandom_range(3) == 0)
                        to_val = 8'($urandom);
                    else
                        to_val = 8'($urandom_range(0, 12));
                end
            endcase
            write_reg(CFG_TIMEOUT, to_val);
            write_reg(CFG_START, sc_val);
            write_reg(CFG_END, ec_val);
            settings++;

            // first phase runs with no idling on either side
            no_idle = (p == 0);
            // receiver holds off while the sender keeps offering frames
            if (p == 4)
                holdoff_asked++;

            repeat ((p == 0 || p == 4) ? 3 : $urandom_range(1, 2)) random_frame();
        end

        drain();
        $display("%0d input beats (%0d bytes) gave %0d frames and %0d result beats",
                 beats_sent, bytes_sent, headers_seen, results_checked);
        $display("%0d register writes over %0d settings, %0d mismatches",
                 cfg_writes, settings, mismatches);
        if (mismatches == 0)
            $display("tb_stx_etx_frame_receiver_unit passed");
        else
            $display("tb_stx_etx_frame_receiver_unit failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/stx_pkg.sv
hw/rtl/stx_frame_parser.sv
hw/rtl/stx_desc_fifo.sv
hw/rtl/stx_result_emitter.sv
hw/rtl/stx_etx_frame_receiver_unit.sv
sim/tb_stx_etx_frame_receiver_unit.sv
